[rtl/nfc_command_state_machine_assert.svh]
// Assertion macros for the command state machine RTL.
`ifndef NFC_COMMAND_STATE_MACHINE_ASSERT_SVH
`define NFC_COMMAND_STATE_MACHINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define NFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define NFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nfc_csm_pkg.sv]
`timescale 1ns / 1ps

package nfc_csm_pkg;

    // Host command and backend event codes
    localparam logic [3:0] OP_STARTUP      = 4'd0;
    localparam logic [3:0] OP_RESULT_CHECK = 4'd1;
    localparam logic [3:0] OP_ABORT        = 4'd2;
    localparam logic [3:0] OP_SHUTDOWN     = 4'd3;
    localparam logic [3:0] OP_PT_SEND      = 4'd4;
    localparam logic [3:0] OP_PT_RECEIVE   = 4'd5;
    localparam logic [3:0] OP_SET_MODE     = 4'd6;
    localparam logic [3:0] OP_ANTENNA      = 4'd7;
    localparam logic [3:0] OP_READ_START   = 4'd8;
    localparam logic [3:0] OP_READ_FETCH   = 4'd9;
    localparam logic [3:0] OP_WRITE        = 4'd10;
    localparam logic [3:0] OP_UNIMPL       = 4'd11;
    localparam logic [3:0] OP_DISC_DONE    = 4'd12;
    localparam logic [3:0] OP_XFER_DONE    = 4'd13;

    // Wire result bytes
    localparam logic [7:0] RES_OK           = 8'h00;
    localparam logic [7:0] RES_TIMEOUT      = 8'h01;
    localparam logic [7:0] RES_NOT_STARTED  = 8'h02;
    localparam logic [7:0] RES_NOTHING      = 8'h03;
    localparam logic [7:0] RES_ABORT_REF    = 8'h06;
    localparam logic [7:0] RES_SHUTDOWN_REF = 8'h07;
    localparam logic [7:0] RES_WRONG_STATE  = 8'h08;
    localparam logic [7:0] RES_BAD_MODE     = 8'h0f;
    localparam logic [7:0] RES_SEND_REF     = 8'h11;
    localparam logic [7:0] RES_ANTENNA_REF  = 8'h16;

    // Backend transfer requests
    localparam logic [1:0] XFER_NONE  = 2'd0;
    localparam logic [1:0] XFER_READ  = 2'd1;
    localparam logic [1:0] XFER_WRITE = 2'd2;

    // Discovery outcomes
    localparam logic [1:0] DISC_FOUND   = 2'd0;
    localparam logic [1:0] DISC_TIMEOUT = 2'd1;

    typedef struct packed {
        logic [3:0]  operation;
        logic        power_sel;
        logic        disc_enable;
        logic [7:0]  mode_value;
        logic [15:0] timeout_ticks;
        logic [1:0]  discovery_outcome;
        logic [7:0]  transfer_code;
    } nfc_cmd_t;

    typedef struct packed {
        logic [7:0]  result_code;
        logic        command_done;
        logic        tag_found;
        logic        reader_mode;
        logic        initialized_flag;
        logic        power_flag;
        logic        discover_request;
        logic [15:0] discover_timeout;
        logic        abort_request;
        logic [1:0]  transfer_request;
    } nfc_rsp_t;

endpackage

[rtl/nfc_csm_core.sv]
`timescale 1ns / 1ps

module nfc_csm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  nfc_csm_pkg::nfc_cmd_t item,
    output nfc_csm_pkg::nfc_rsp_t result
);
    import nfc_csm_pkg::*;

    `include "nfc_command_state_machine_assert.svh"

    typedef enum logic [3:0] {
        ST_UNINIT   = 4'd0,
        ST_INIT     = 4'd1,
        ST_READY    = 4'd2,
        ST_DISC     = 4'd3,
        ST_FOUND    = 4'd4,
        ST_DONE     = 4'd5,
        ST_ABORTED  = 4'd6,
        ST_MDISC    = 4'd7,
        ST_MFOUND   = 4'd8,
        ST_ACHECK   = 4'd9,
        ST_ACHECKED = 4'd10
    } reader_state_t;

    typedef enum logic [1:0] {
        JOB_NONE  = 2'd0,
        JOB_PT    = 2'd1,
        JOB_READ  = 2'd2,
        JOB_WRITE = 2'd3
    } job_t;

    reader_state_t state_reg, state_next;
    job_t          job_reg, job_next;
    logic [7:0]    stored_reg, stored_next;
    logic [15:0]   timeout_reg, timeout_next;
    logic          done_reg, done_next;
    logic          tag_reg, tag_next;
    logic          mode_reg, mode_next;
    logic          init_reg, init_next;
    logic          power_reg, power_next;

    logic          in_xfer;
    logic [7:0]    res;
    logic          disc;
    logic          abrt;
    logic [1:0]    xfer;

    assign in_xfer = ((job_reg == JOB_READ) || (job_reg == JOB_WRITE)) && mode_reg;

    // Decode one command or event against the current reader state
    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        stored_next  = stored_reg;
        timeout_next = timeout_reg;
        done_next    = done_reg;
        tag_next     = tag_reg;
        mode_next    = mode_reg;
        init_next    = init_reg;
        power_next   = power_reg;
        res          = RES_OK;
        disc         = 1'b0;
        abrt         = 1'b0;
        xfer         = XFER_NONE;

        case (item.operation)
            OP_STARTUP:
            begin
                done_next  = 1'b0;
                state_next = ST_READY;
                job_next   = JOB_NONE;
                power_next = item.power_sel;
                mode_next  = 1'b0;
                init_next  = 1'b1;
            end
            OP_RESULT_CHECK:
            begin
                if (state_reg == ST_INIT)
                    res = RES_NOT_STARTED;
                else if (state_reg == ST_DONE || state_reg == ST_ABORTED ||
                         state_reg == ST_MFOUND || state_reg == ST_ACHECKED)
                begin
                    done_next  = 1'b0;
                    tag_next   = 1'b0;
                    state_next = (state_reg == ST_ACHECKED) ? ST_INIT : ST_READY;
                    res        = stored_reg;
                end
                else
                    res = RES_WRONG_STATE;
            end
            OP_ABORT:
            begin
                if (state_reg == ST_INIT)
                    res = RES_NOT_STARTED;
                else if (state_reg == ST_DISC || state_reg == ST_MDISC)
                begin
                    state_next = ST_ABORTED;
                    abrt       = 1'b1;
                end
                else if (state_reg == ST_FOUND)
                    state_next = ST_ABORTED;
                else
                    res = RES_ABORT_REF;
            end
            OP_SHUTDOWN:
            begin
                if (state_reg == ST_ACHECKED)
                    done_next = 1'b0;
                else if (state_reg == ST_READY)
                begin
                    state_next = ST_INIT;
                    init_next  = 1'b0;
                    power_next = 1'b0;
                end
                else
                    res = RES_SHUTDOWN_REF;
            end
            OP_PT_SEND:
            begin
                if (state_reg == ST_INIT)
                    res = RES_NOT_STARTED;
                else if (state_reg == ST_READY)
                begin
                    timeout_next = item.timeout_ticks;
                    if (item.disc_enable)
                    begin
                        job_next   = JOB_PT;
                        state_next = ST_DISC;
                        disc       = 1'b1;
                    end
                    else
                        res = RES_SEND_REF;
                end
                else
                    res = RES_WRONG_STATE;
            end
            OP_PT_RECEIVE:
            begin
                if (state_reg == ST_INIT)
                    res = RES_NOT_STARTED;
                else if (state_reg == ST_DONE || state_reg == ST_ABORTED)
                begin
                    done_next  = 1'b0;
                    state_next = ST_READY;
                    res        = stored_reg;
                end
                else
                    res = RES_WRONG_STATE;
            end
            OP_SET_MODE:
            begin
                if (state_reg == ST_INIT)
                    res = RES_NOT_STARTED;
                else if (state_reg == ST_READY)
                begin
                    if (item.mode_value == 8'd0)
                        mode_next = 1'b0;
                    else
                        res = RES_BAD_MODE;
                end
                else
                    res = RES_WRONG_STATE;
            end
            OP_ANTENNA:
            begin
                if (state_reg == ST_INIT)
                begin
                    done_next   = 1'b1;
                    state_next  = ST_ACHECKED;
                    stored_next = RES_OK;
                end
                else
                    res = RES_ANTENNA_REF;
            end
            OP_READ_START, OP_WRITE:
            begin
                if (state_reg == ST_INIT)
                    res = RES_NOT_STARTED;
                else if (state_reg == ST_READY)
                begin
                    timeout_next = item.timeout_ticks;
                    job_next     = (item.operation == OP_READ_START) ? JOB_READ : JOB_WRITE;
                    state_next   = ST_DISC;
                    disc         = 1'b1;
                end
                else
                    res = RES_WRONG_STATE;
            end
            OP_READ_FETCH:
            begin
                if (state_reg == ST_INIT)
                    res = RES_NOT_STARTED;
                else if (state_reg == ST_UNINIT || state_reg == ST_READY)
                    res = RES_NOTHING;
                else if (state_reg == ST_DONE || state_reg == ST_ABORTED ||
                         state_reg == ST_MFOUND)
                begin
                    done_next  = 1'b0;
                    tag_next   = 1'b0;
                    state_next = ST_READY;
                    res        = stored_reg;
                end
                else
                    res = RES_WRONG_STATE;
            end
            OP_DISC_DONE:
            begin
                // Drop the event unless a discovery is actually running
                if (job_reg != JOB_NONE && !in_xfer)
                begin
                    if (item.discovery_outcome != DISC_FOUND)
                    begin
                        if (state_reg == ST_ABORTED)
                            stored_next = RES_ABORT_REF;
                        else if (item.discovery_outcome == DISC_TIMEOUT)
                        begin
                            state_next  = ST_DONE;
                            stored_next = RES_TIMEOUT;
                        end
                        else
                            stored_next = RES_ABORT_REF;
                        done_next = 1'b1;
                        job_next  = JOB_NONE;
                    end
                    else if (job_reg == JOB_PT)
                    begin
                        mode_next  = 1'b1;
                        state_next = ST_DONE;
                        done_next  = 1'b1;
                        job_next   = JOB_NONE;
                    end
                    else
                    begin
                        state_next = ST_FOUND;
                        tag_next   = 1'b1;
                        mode_next  = 1'b1;
                        xfer       = (job_reg == JOB_READ) ? XFER_READ : XFER_WRITE;
                    end
                end
                res = stored_next;
            end
            OP_XFER_DONE:
            begin
                // Drop the event unless a transfer is actually running
                if (in_xfer)
                begin
                    stored_next = item.transfer_code;
                    mode_next   = 1'b0;
                    state_next  = ST_DONE;
                    done_next   = 1'b1;
                    job_next    = JOB_NONE;
                end
                res = stored_next;
            end
            default:
                res = RES_NOT_STARTED;
        endcase
    end

    // Assemble the result transaction from the updated state
    always_comb
    begin
        result.result_code      = res;
        result.command_done     = done_next;
        result.tag_found        = tag_next;
        result.reader_mode      = mode_next;
        result.initialized_flag = init_next;
        result.power_flag       = power_next;
        result.discover_request = disc;
        result.discover_timeout = timeout_next;
        result.abort_request    = abrt;
        result.transfer_request = xfer;
    end

    // Hold reader state; advance only when a transaction is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            job_reg     <= JOB_NONE;
            stored_reg  <= 8'd0;
            timeout_reg <= 16'd0;
            done_reg    <= 1'b0;
            tag_reg     <= 1'b0;
            mode_reg    <= 1'b0;
            init_reg    <= 1'b0;
            power_reg   <= 1'b0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            stored_reg  <= stored_next;
            timeout_reg <= timeout_next;
            done_reg    <= done_next;
            tag_reg     <= tag_next;
            mode_reg    <= mode_next;
            init_reg    <= init_next;
            power_reg   <= power_next;
        end
    end

    `NFC_ASSERT_NEXT(a_startup_ready, fire && item.operation == OP_STARTUP,
        state_reg == ST_READY && job_reg == JOB_NONE && init_reg,
        "startup did not leave the reader ready")

    `NFC_ASSERT_NEXT(a_xfer_from_found, fire && result.transfer_request != XFER_NONE,
        state_reg == ST_FOUND && tag_reg && mode_reg && job_reg != JOB_NONE,
        "transfer requested without a discovered tag")

    `NFC_ASSERT_NEXT(a_idle_hold, !fire,
        $stable(state_reg) && $stable(job_reg) && $stable(stored_reg),
        "reader state changed without a transaction")

endmodule

[rtl/nfc_command_state_machine.sv]
`timescale 1ns / 1ps
// The decode is one pass between the command (input) and response registers.
// Throughput: one command per cycle while the response register is not stalled.
// A stalled response holds in its register while one further command waits in the input reg.
// Reset (rst_n, async, active low): reader initialized, no job, result, timeout and flags zero,
// both pipeline registers empty.

module nfc_command_state_machine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  nfc_csm_pkg::nfc_cmd_t cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output nfc_csm_pkg::nfc_rsp_t rsp
);
    import nfc_csm_pkg::*;

    logic     stage_valid_reg;
    nfc_cmd_t stage_reg;
    logic     rsp_valid_reg;
    nfc_rsp_t rsp_reg;
    logic     stage_adv;
    logic     fire;
    nfc_rsp_t result;

    // Move the input stage whenever the response register is free or draining
    assign stage_adv = !rsp_valid_reg || rsp_ready;
    assign fire      = stage_valid_reg && stage_adv;
    assign cmd_ready = !stage_valid_reg || stage_adv;

    nfc_csm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (stage_reg),
        .result (result)
    );

    // Track occupancy of the input and response registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
                stage_valid_reg <= cmd_valid;
            if (stage_adv)
                rsp_valid_reg <= stage_valid_reg;
        end
    end

    // Capture command and response payloads
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            stage_reg <= cmd;
        if (fire)
            rsp_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import nfc_csm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED = 50;
    localparam logic [1:0] DISC_ERROR = 2'd2;

    // Reader states, as held in the state register
    typedef enum logic [3:0] {
        RS_UNINIT   = 4'd0,
        RS_INIT     = 4'd1,
        RS_READY    = 4'd2,
        RS_DISC     = 4'd3,
        RS_FOUND    = 4'd4,
        RS_DONE     = 4'd5,
        RS_ABORTED  = 4'd6,
        RS_MDISC    = 4'd7,
        RS_MFOUND   = 4'd8,
        RS_ACHECK   = 4'd9,
        RS_ACHECKED = 4'd10
    } reader_state_e;

    // Job handed to the backend
    typedef enum logic [1:0] {
        JOB_NONE  = 2'd0,
        JOB_PT    = 2'd1,
        JOB_READ  = 2'd2,
        JOB_WRITE = 2'd3
    } job_e;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    nfc_cmd_t cmd = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    nfc_rsp_t rsp;

    // Shadow copy of the reader registers
    logic [3:0]  rdr_state;
    job_e        job;
    logic [7:0]  last_result;
    logic [15:0] disc_tmo;
    logic        flag_done;
    logic        flag_tag;
    logic        flag_mode;
    logic        flag_init;
    logic        flag_power;

    nfc_rsp_t expected_rsp_q[$];
    int       err_count = 0;
    int       rsp_count = 0;
    int       sent_items = 0;
    int       idle_cycles = 0;
    int       stall_left = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    nfc_command_state_machine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the response to one command and advance the shadow registers
    function automatic nfc_rsp_t predict_response(nfc_cmd_t c);
        nfc_rsp_t   r;
        logic [3:0] st;
        logic       in_xfer;
        r = '0;
        st = rdr_state;
        in_xfer = (job == JOB_READ || job == JOB_WRITE) && flag_mode;
        r.result_code = RES_OK;
        case (c.operation)
            OP_STARTUP:
            begin
                flag_done = 1'b0;
                rdr_state = RS_READY;
                job = JOB_NONE;
                flag_power = c.power_sel;
                flag_mode = 1'b0;
                flag_init = 1'b1;
            end
            OP_RESULT_CHECK:
            begin
                if (st == RS_INIT)
                    r.result_code = RES_NOT_STARTED;
                else if (st == RS_DONE || st == RS_ABORTED || st == RS_MFOUND ||
                         st == RS_ACHECKED)
                begin
                    flag_done = 1'b0;
                    flag_tag = 1'b0;
                    rdr_state = (st == RS_ACHECKED) ? RS_INIT : RS_READY;
                    r.result_code = last_result;
                end
                else
                    r.result_code = RES_WRONG_STATE;
            end
            OP_ABORT:
            begin
                if (st == RS_INIT)
                    r.result_code = RES_NOT_STARTED;
                else if (st == RS_DISC || st == RS_MDISC)
                begin
                    rdr_state = RS_ABORTED;
                    r.abort_request = 1'b1;
                end
                else if (st == RS_FOUND)
                    rdr_state = RS_ABORTED;
                else
                    r.result_code = RES_ABORT_REF;
            end
            OP_SHUTDOWN:
            begin
                if (st == RS_ACHECKED)
                    flag_done = 1'b0;
                else if (st == RS_READY)
                begin
                    rdr_state = RS_INIT;
                    flag_init = 1'b0;
                    flag_power = 1'b0;
                end
                else
                    r.result_code = RES_SHUTDOWN_REF;
            end
            OP_PT_SEND:
            begin
                if (st == RS_INIT)
                    r.result_code = RES_NOT_STARTED;
                else if (st == RS_READY)
                begin
                    disc_tmo = c.timeout_ticks;
                    if (c.disc_enable)
                    begin
                        job = JOB_PT;
                        rdr_state = RS_DISC;
                        r.discover_request = 1'b1;
                    end
                    else
                        r.result_code = RES_SEND_REF;
                end
                else
                    r.result_code = RES_WRONG_STATE;
            end
            OP_PT_RECEIVE:
            begin
                if (st == RS_INIT)
                    r.result_code = RES_NOT_STARTED;
                else if (st == RS_DONE || st == RS_ABORTED)
                begin
                    flag_done = 1'b0;
                    rdr_state = RS_READY;
                    r.result_code = last_result;
                end
                else
                    r.result_code = RES_WRONG_STATE;
            end
            OP_SET_MODE:
            begin
                if (st == RS_INIT)
                    r.result_code = RES_NOT_STARTED;
                else if (st == RS_READY)
                begin
                    if (c.mode_value == 8'd0)
                        flag_mode = 1'b0;
                    else
                        r.result_code = RES_BAD_MODE;
                end
                else
                    r.result_code = RES_WRONG_STATE;
            end
            OP_ANTENNA:
            begin
                if (st == RS_INIT)
                begin
                    flag_done = 1'b1;
                    rdr_state = RS_ACHECKED;
                    last_result = RES_OK;
                end
                else
                    r.result_code = RES_ANTENNA_REF;
            end
            OP_READ_START, OP_WRITE:
            begin
                if (st == RS_INIT)
                    r.result_code = RES_NOT_STARTED;
                else if (st == RS_READY)
                begin
                    disc_tmo = c.timeout_ticks;
                    job = (c.operation == OP_READ_START) ? JOB_READ : JOB_WRITE;
                    rdr_state = RS_DISC;
                    r.discover_request = 1'b1;
                end
                else
                    r.result_code = RES_WRONG_STATE;
            end
            OP_READ_FETCH:
            begin
                if (st == RS_INIT)
                    r.result_code = RES_NOT_STARTED;
                else if (st == RS_UNINIT || st == RS_READY)
                    r.result_code = RES_NOTHING;
                else if (st == RS_DONE || st == RS_ABORTED || st == RS_MFOUND)
                begin
                    flag_done = 1'b0;
                    flag_tag = 1'b0;
                    rdr_state = RS_READY;
                    r.result_code = last_result;
                end
                else
                    r.result_code = RES_WRONG_STATE;
            end
            OP_DISC_DONE:
            begin
                // Only a discovery in progress reacts; a stray event is ignored
                if (job != JOB_NONE && !in_xfer)
                begin
                    if (c.discovery_outcome != DISC_FOUND)
                    begin
                        if (st == RS_ABORTED)
                            last_result = RES_ABORT_REF;
                        else if (c.discovery_outcome == DISC_TIMEOUT)
                        begin
                            rdr_state = RS_DONE;
                            last_result = RES_TIMEOUT;
                        end
                        else
                            last_result = RES_ABORT_REF;
                        flag_done = 1'b1;
                        job = JOB_NONE;
                    end
                    else if (job == JOB_PT)
                    begin
                        flag_mode = 1'b1;
                        rdr_state = RS_DONE;
                        flag_done = 1'b1;
                        job = JOB_NONE;
                    end
                    else
                    begin
                        rdr_state = RS_FOUND;
                        flag_tag = 1'b1;
                        flag_mode = 1'b1;
                        r.transfer_request = (job == JOB_READ) ? XFER_READ : XFER_WRITE;
                    end
                end
                r.result_code = last_result;
            end
            OP_XFER_DONE:
            begin
                if (in_xfer)
                begin
                    last_result = c.transfer_code;
                    flag_mode = 1'b0;
                    rdr_state = RS_DONE;
                    flag_done = 1'b1;
                    job = JOB_NONE;
                end
                r.result_code = last_result;
            end
            default:
                r.result_code = RES_NOT_STARTED;
        endcase
        r.command_done = flag_done;
        r.tag_found = flag_tag;
        r.reader_mode = flag_mode;
        r.initialized_flag = flag_init;
        r.power_flag = flag_power;
        r.discover_timeout = disc_tmo;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("response %0d %s got %0h expected %0h",
                                      rsp_count, name, got, exp));
    endtask

    // Check responses, predict commands, and watch for a hang
    always @(posedge clk)
    begin
        nfc_rsp_t exp;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch($sformatf("response %0d with nothing outstanding",
                                              rsp_count));
                else
                begin
                    exp = expected_rsp_q.pop_front();
                    compare_field("result_code", 16'(rsp.result_code),
                                  16'(exp.result_code));
                    compare_field("command_done", 16'(rsp.command_done),
                                  16'(exp.command_done));
                    compare_field("tag_found", 16'(rsp.tag_found), 16'(exp.tag_found));
                    compare_field("reader_mode", 16'(rsp.reader_mode),
                                  16'(exp.reader_mode));
                    compare_field("initialized_flag", 16'(rsp.initialized_flag),
                                  16'(exp.initialized_flag));
                    compare_field("power_flag", 16'(rsp.power_flag), 16'(exp.power_flag));
                    compare_field("discover_request", 16'(rsp.discover_request),
                                  16'(exp.discover_request));
                    compare_field("discover_timeout", rsp.discover_timeout,
                                  exp.discover_timeout);
                    compare_field("abort_request", 16'(rsp.abort_request),
                                  16'(exp.abort_request));
                    compare_field("transfer_request", 16'(rsp.transfer_request),
                                  16'(exp.transfer_request));
                end
                rsp_count++;
            end
            if (cmd_valid && cmd_ready)
                expected_rsp_q.push_back(predict_response(cmd));
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("[%0t] no transaction for %0d cycles", $time, idle_cycles);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // Response side: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic nfc_cmd_t any_cmd(input logic [3:0] op);
        nfc_cmd_t c;
        c.operation = op;
        c.power_sel = 1'($urandom_range(1));
        c.disc_enable = 1'($urandom_range(1));
        c.mode_value = 8'($urandom_range(255));
        c.timeout_ticks = 16'($urandom_range(65535));
        c.discovery_outcome = 2'($urandom_range(3));
        c.transfer_code = 8'($urandom_range(255));
        return c;
    endfunction

    // Offer one command and hold it until the transaction completes
    task automatic send_cmd(input nfc_cmd_t c);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_op(input logic [3:0] op);
        send_cmd(any_cmd(op));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Commands from the initialized state, antenna check and shutdown paths
    task automatic test_power_and_antenna();
        nfc_cmd_t c;
        send_op(OP_RESULT_CHECK);
        send_op(OP_ANTENNA);
        send_op(OP_SHUTDOWN);
        send_op(OP_RESULT_CHECK);
        c = any_cmd(OP_STARTUP);
        c.power_sel = 1'b1;
        send_cmd(c);
        c = any_cmd(OP_SET_MODE);
        c.mode_value = 8'hff;
        send_cmd(c);
        c.mode_value = 8'h00;
        send_cmd(c);
        wait_drain();
    endtask

    // Pass-through, read and write jobs through discovery and transfer
    task automatic test_discovery_paths();
        nfc_cmd_t c;
        c = any_cmd(OP_PT_SEND);
        c.disc_enable = 1'b0;
        c.timeout_ticks = 16'hffff;
        send_cmd(c);
        c.disc_enable = 1'b1;
        send_cmd(c);
        c = any_cmd(OP_XFER_DONE);
        c.transfer_code = 8'hff;
        send_cmd(c);
        c = any_cmd(OP_DISC_DONE);
        c.discovery_outcome = DISC_FOUND;
        send_cmd(c);
        send_op(OP_PT_RECEIVE);
        c = any_cmd(OP_READ_START);
        c.timeout_ticks = 16'h0000;
        send_cmd(c);
        send_op(OP_ABORT);
        c = any_cmd(OP_DISC_DONE);
        c.discovery_outcome = DISC_ERROR;
        send_cmd(c);
        send_op(OP_READ_FETCH);
        send_op(OP_WRITE);
        c = any_cmd(OP_DISC_DONE);
        c.discovery_outcome = DISC_TIMEOUT;
        send_cmd(c);
        c.discovery_outcome = DISC_FOUND;
        send_cmd(c);
        send_op(OP_RESULT_CHECK);
        send_op(OP_READ_START);
        c = any_cmd(OP_STARTUP);
        c.power_sel = 1'b0;
        send_cmd(c);
        send_op(OP_READ_START);
        c = any_cmd(OP_DISC_DONE);
        c.discovery_outcome = DISC_FOUND;
        send_cmd(c);
        c = any_cmd(OP_XFER_DONE);
        c.transfer_code = 8'h00;
        send_cmd(c);
        wait_drain();
    endtask

    // Unimplemented and undefined operation codes
    task automatic test_unknown_ops();
        send_op(OP_UNIMPL);
        send_op(4'd14);
        send_op(4'd15);
        wait_drain();
    endtask

    // One randomized command sequence, mostly well formed
    task automatic run_session();
        nfc_cmd_t c;
        int       pick;
        int       n;
        if ($urandom_range(99) < 35)
            send_op(OP_STARTUP);
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            send_op($urandom_range(1) ? OP_READ_START : OP_WRITE);
            if ($urandom_range(99) < 15)
                send_op(OP_ABORT);
            c = any_cmd(OP_DISC_DONE);
            if ($urandom_range(99) < 70)
                c.discovery_outcome = DISC_FOUND;
            send_cmd(c);
            if ($urandom_range(99) < 10)
                send_op(OP_ABORT);
            if ($urandom_range(99) < 10)
                send_op(4'($urandom_range(15)));
            send_op(OP_XFER_DONE);
            send_op(($urandom_range(99) < 60) ? OP_READ_FETCH : OP_RESULT_CHECK);
        end
        else if (pick < 70)
        begin
            c = any_cmd(OP_PT_SEND);
            c.disc_enable = ($urandom_range(99) < 85);
            send_cmd(c);
            if ($urandom_range(99) < 10)
                send_op(OP_ABORT);
            c = any_cmd(OP_DISC_DONE);
            if ($urandom_range(99) < 60)
                c.discovery_outcome = DISC_FOUND;
            send_cmd(c);
            send_op(($urandom_range(99) < 70) ? OP_PT_RECEIVE : OP_RESULT_CHECK);
        end
        else if (pick < 80)
        begin
            send_op(OP_SHUTDOWN);
            send_op(OP_ANTENNA);
            if ($urandom_range(1))
                send_op(OP_SHUTDOWN);
            send_op(OP_RESULT_CHECK);
            send_op(OP_STARTUP);
        end
        else if (pick < 88)
        begin
            c = any_cmd(OP_SET_MODE);
            if ($urandom_range(1))
                c.mode_value = 8'd0;
            send_cmd(c);
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_op(4'($urandom_range(15)));
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = sent_items + count;
        while (sent_items < target)
            run_session();
        wait_drain();
    endtask

    // Hold the response side off so the block fills and stalls its input
    task automatic test_backpressure();
        int target;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left = 80;
        target = sent_items + 30;
        while (sent_items < target)
            run_session();
        wait_drain();
    endtask

    initial
    begin
        rdr_state = RS_INIT;
        job = JOB_NONE;
        last_result = 8'd0;
        disc_tmo = 16'd0;
        flag_done = 1'b0;
        flag_tag = 1'b0;
        flag_mode = 1'b0;
        flag_init = 1'b0;
        flag_power = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 64;
        test_power_and_antenna();
        test_discovery_paths();
        test_unknown_ops();
        test_random_traffic(17, 64, 570);
        test_random_traffic(64, 17, 570);
        test_backpressure();
        test_random_traffic(0, 0, 570);

        repeat (10) @(posedge clk);
        if (expected_rsp_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived",
                                      expected_rsp_q.size()));
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
